FILE: rtl/mbid_pkg.sv
`timescale 1ns / 1ps
package mbid_pkg;

  // Width of the pointer fields on the ports.
  localparam int PTR_W = 12;

  // Request codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes.
  localparam logic STAT_OK   = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic alloc_start;
    logic free_start;
    logic scan;
    logic free_seek;
    logic free_clear;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic hit;
    logic fail;
    logic rem_small;
  } stat_t;

endpackage

FILE: rtl/mbid_ram.sv
`timescale 1ns / 1ps
module mbid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 22
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/mbid_ctrl.sv
`timescale 1ns / 1ps
module mbid_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               req_type_i,
  output logic               busy,
  output mbid_pkg::cmd_t     cmd_o,
  input  mbid_pkg::stat_t    stat_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FSEEK = 3'd3;
  localparam logic [2:0] S_FCLR  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_type_i == mbid_pkg::REQ_FREE) begin
            cmd_o.free_start = 1'b1;
            state_d          = S_FSEEK;
          end else begin
            cmd_o.alloc_start = 1'b1;
            state_d           = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.hit || stat_i.fail) begin
          state_d = S_IDLE;
        end
      end
      S_FSEEK: begin
        cmd_o.free_seek = 1'b1;
        if (stat_i.rem_small) begin
          state_d = S_FCLR;
        end
      end
      S_FCLR: begin
        cmd_o.free_clear = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

FILE: rtl/mbid_dp.sv
`timescale 1ns / 1ps
module mbid_dp #(
  parameter int SLOT_BITS   = 4,
  parameter int FANOUT_BITS = 2,
  parameter int DEPTH_BITS  = 2,
  parameter int LEVEL_SHIFT = 10,
  parameter int WORD_BITS   = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbid_pkg::cmd_t                cmd_i,
  output mbid_pkg::stat_t               stat_o,
  input  logic [mbid_pkg::PTR_W-1:0]    slot_pointer_i,
  output logic                          done_o,
  output logic                          status_o,
  output logic [mbid_pkg::PTR_W-1:0]    allocated_pointer_o
);

  localparam int NUM_LEVELS = 1 << DEPTH_BITS;
  localparam int LVL_W      = (DEPTH_BITS > 0) ? DEPTH_BITS : 1;
  localparam int MAX_LB     = SLOT_BITS + (NUM_LEVELS - 1) * FANOUT_BITS;
  localparam int IDX_W      = MAX_LB + 8;
  localparam int BIT_W      = $clog2(WORD_BITS);

  // Words per level; levels are packed one after the other in the memory.
  localparam longint unsigned LW0 = (NUM_LEVELS > 0) ?
    ((64'd1 << (SLOT_BITS + 0 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;
  localparam longint unsigned LW1 = (NUM_LEVELS > 1) ?
    ((64'd1 << (SLOT_BITS + 1 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;
  localparam longint unsigned LW2 = (NUM_LEVELS > 2) ?
    ((64'd1 << (SLOT_BITS + 2 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;
  localparam longint unsigned LW3 = (NUM_LEVELS > 3) ?
    ((64'd1 << (SLOT_BITS + 3 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;
  localparam longint unsigned LW4 = (NUM_LEVELS > 4) ?
    ((64'd1 << (SLOT_BITS + 4 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;
  localparam longint unsigned LW5 = (NUM_LEVELS > 5) ?
    ((64'd1 << (SLOT_BITS + 5 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;
  localparam longint unsigned LW6 = (NUM_LEVELS > 6) ?
    ((64'd1 << (SLOT_BITS + 6 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;
  localparam longint unsigned LW7 = (NUM_LEVELS > 7) ?
    ((64'd1 << (SLOT_BITS + 7 * FANOUT_BITS)) + WORD_BITS - 1) / WORD_BITS : 0;

  localparam longint unsigned TOTAL_WORDS = LW0 + LW1 + LW2 + LW3 + LW4 + LW5 + LW6 + LW7;
  localparam int ADDR_W = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;

  localparam longint unsigned LVL_BASE [8] = '{
    0,
    LW0,
    LW0 + LW1,
    LW0 + LW1 + LW2,
    LW0 + LW1 + LW2 + LW3,
    LW0 + LW1 + LW2 + LW3 + LW4,
    LW0 + LW1 + LW2 + LW3 + LW4 + LW5,
    LW0 + LW1 + LW2 + LW3 + LW4 + LW5 + LW6
  };

  localparam int LVL_LB [8] = '{
    SLOT_BITS,
    SLOT_BITS + 1 * FANOUT_BITS,
    SLOT_BITS + 2 * FANOUT_BITS,
    SLOT_BITS + 3 * FANOUT_BITS,
    SLOT_BITS + 4 * FANOUT_BITS,
    SLOT_BITS + 5 * FANOUT_BITS,
    SLOT_BITS + 6 * FANOUT_BITS,
    SLOT_BITS + 7 * FANOUT_BITS
  };

  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEVELS - 1);
  localparam logic [IDX_W-1:0] WORD_N   = IDX_W'(WORD_BITS);

  // Issue side: the word whose read goes out this cycle.
  logic [ADDR_W-1:0] i_addr_q, i_addr_d;
  logic [LVL_W-1:0]  i_lvl_q, i_lvl_d;
  logic [IDX_W-1:0]  i_base_q, i_base_d;
  logic              i_more_q, i_more_d;
  // Evaluate side: the word whose read data is on the memory output.
  logic [ADDR_W-1:0] e_addr_q;
  logic [LVL_W-1:0]  e_lvl_q;
  logic [IDX_W-1:0]  e_base_q;
  logic              e_last_q;
  logic              e_valid_q, e_valid_d;
  logic [ADDR_W-1:0] clr_addr_q;

  logic                       done_q, done_d;
  logic                       status_q, status_d;
  logic [mbid_pkg::PTR_W-1:0] ptr_q, ptr_d;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;

  logic [IDX_W-1:0]       i_size, i_next_base;
  logic                   i_lvl_end;
  logic [mbid_pkg::PTR_W-1:0] ptr_shift;
  logic [LVL_W-1:0]       f_lvl;
  logic [IDX_W-1:0]       f_idx;
  logic [IDX_W-1:0]       e_size, e_rem, e_slot;
  logic [WORD_BITS-1:0]   e_mask, e_busy;
  logic                   e_found;
  logic [BIT_W-1:0]       e_pos;
  logic                   hit, fail, rem_small;
  logic [mbid_pkg::PTR_W-1:0] alloc_ptr;

  // Issue side walk over the words of all levels.
  always_comb begin
    i_size      = IDX_W'(1) << LVL_LB[3'(i_lvl_q)];
    i_next_base = i_base_q + WORD_N;
    i_lvl_end   = (i_next_base >= i_size);
  end

  // Level and masked index of a pointer to free.
  always_comb begin
    ptr_shift = slot_pointer_i >> LEVEL_SHIFT;
    f_lvl     = (DEPTH_BITS > 0) ? ptr_shift[LVL_W-1:0] : '0;
    f_idx     = IDX_W'(slot_pointer_i) & ((IDX_W'(1) << LVL_LB[3'(f_lvl)]) - IDX_W'(1));
  end

  // Find the first free slot in the word under evaluation. Bits past the end
  // of the level count as used.
  always_comb begin
    e_size  = IDX_W'(1) << LVL_LB[3'(e_lvl_q)];
    e_rem   = e_size - e_base_q;
    e_mask  = (e_rem >= WORD_N) ? {WORD_BITS{1'b1}} :
              ~({WORD_BITS{1'b1}} << e_rem[BIT_W-1:0]);
    e_busy  = ram_rdata | ~e_mask;
    e_found = 1'b0;
    e_pos   = '0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (!e_busy[p]) begin
        e_found = 1'b1;
        e_pos   = BIT_W'(p);
      end
    end
    e_slot    = e_base_q + IDX_W'(e_pos);
    alloc_ptr = mbid_pkg::PTR_W'(e_slot) |
                (mbid_pkg::PTR_W'(e_lvl_q) << LEVEL_SHIFT);
  end

  assign hit       = e_valid_q && e_found;
  assign fail      = e_valid_q && !e_found && e_last_q;
  assign rem_small = (i_base_q < WORD_N);

  always_comb begin
    stat_o.clr_done  = (clr_addr_q == ADDR_W'(TOTAL_WORDS - 1));
    stat_o.hit       = hit;
    stat_o.fail      = fail;
    stat_o.rem_small = rem_small;
  end

  // Issue side and evaluate pipeline updates.
  always_comb begin
    i_addr_d  = i_addr_q;
    i_lvl_d   = i_lvl_q;
    i_base_d  = i_base_q;
    i_more_d  = i_more_q;
    e_valid_d = e_valid_q;
    priority if (cmd_i.alloc_start) begin
      i_addr_d  = '0;
      i_lvl_d   = '0;
      i_base_d  = '0;
      i_more_d  = 1'b1;
      e_valid_d = 1'b0;
    end else if (cmd_i.free_start) begin
      i_addr_d  = ADDR_W'(LVL_BASE[3'(f_lvl)]);
      i_lvl_d   = f_lvl;
      i_base_d  = f_idx;
      i_more_d  = 1'b0;
      e_valid_d = 1'b0;
    end else if (cmd_i.scan) begin
      e_valid_d = i_more_q;
      if (i_more_q) begin
        i_addr_d = i_addr_q + ADDR_W'(1);
        if (i_lvl_end) begin
          i_base_d = '0;
          if (i_lvl_q == LAST_LVL) begin
            i_more_d = 1'b0;
          end else begin
            i_lvl_d = i_lvl_q + LVL_W'(1);
          end
        end else begin
          i_base_d = i_next_base;
        end
      end
    end else if (cmd_i.free_seek && !rem_small) begin
      i_addr_d = i_addr_q + ADDR_W'(1);
      i_base_d = i_base_q - WORD_N;
    end else begin
      i_more_d = i_more_q;
    end
  end

  // Memory port selection.
  always_comb begin
    ram_re    = (cmd_i.scan && i_more_q) || (cmd_i.free_seek && rem_small);
    ram_we    = 1'b0;
    ram_waddr = i_addr_q;
    ram_wdata = ram_rdata & ~(WORD_BITS'(1) << i_base_q[BIT_W-1:0]);
    priority if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      // Slot 0 of level 0 is reserved at reset.
      ram_wdata = (clr_addr_q == '0) ? WORD_BITS'(1) : '0;
    end else if (cmd_i.scan && hit) begin
      ram_we    = 1'b1;
      ram_waddr = e_addr_q;
      ram_wdata = ram_rdata | (WORD_BITS'(1) << e_pos);
    end else if (cmd_i.free_clear) begin
      ram_we = 1'b1;
    end else begin
      ram_we = 1'b0;
    end
  end

  always_comb begin
    done_d   = (cmd_i.scan && (hit || fail)) || cmd_i.free_clear;
    status_d = (cmd_i.scan && fail) ? mbid_pkg::STAT_FULL : mbid_pkg::STAT_OK;
    ptr_d    = (cmd_i.scan && hit) ? alloc_ptr : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_more_q   <= 1'b0;
      e_valid_q  <= 1'b0;
      clr_addr_q <= '0;
      done_q     <= 1'b0;
    end else begin
      i_more_q  <= i_more_d;
      e_valid_q <= e_valid_d;
      done_q    <= done_d;
      if (cmd_i.clr_step) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_addr_q <= i_addr_d;
    i_lvl_q  <= i_lvl_d;
    i_base_q <= i_base_d;
    status_q <= status_d;
    ptr_q    <= ptr_d;
    if (cmd_i.scan) begin
      e_addr_q <= i_addr_q;
      e_lvl_q  <= i_lvl_q;
      e_base_q <= i_base_q;
      e_last_q <= i_lvl_end && (i_lvl_q == LAST_LVL);
    end
  end

  mbid_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (int'(TOTAL_WORDS))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (i_addr_q),
    .rdata_o (ram_rdata)
  );

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign allocated_pointer_o = ptr_q;

endmodule

FILE: rtl/multilevel_bitmap_id_allocator_core.sv
`timescale 1ns / 1ps
// Multilevel bitmap slot allocator.
// A request word (req_type_i, slot_pointer_i) is taken at a rising edge where
// start is high and busy is low. Allocate hands out the lowest free slot,
// scanning level 0 first; free clears the slot that the pointer names.
// Each request gives exactly one result word, held for one cycle with done_o
// high; the receiver cannot stall it, and a new request may be taken in the
// same cycle that done_o is high.
// An allocate scans the bitmap words in order over all levels and stops at
// the first word that holds a free slot; with all levels full it gives the
// out-of-slots result after the last word. The scan reads one memory word per
// cycle from the single bitmap RAM, which sets the rate. A free steps word by
// word to the slot's word, then reads that word and writes it back with the
// slot cleared.
// After reset the block clears the bitmap RAM one word per cycle, holding
// busy high until all TOTAL_WORDS words (22 at default sizes) are written;
// slot 0 of level 0 comes out of reset reserved.
module multilevel_bitmap_id_allocator_core #(
  parameter int SLOT_BITS   = 4,
  parameter int FANOUT_BITS = 2,
  parameter int DEPTH_BITS  = 2,
  parameter int LEVEL_SHIFT = 10,
  parameter int WORD_BITS   = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       req_type_i,
  input  logic [mbid_pkg::PTR_W-1:0] slot_pointer_i,
  output logic                       done_o,
  output logic                       status_o,
  output logic [mbid_pkg::PTR_W-1:0] allocated_pointer_o
);

  mbid_pkg::cmd_t  cmd;
  mbid_pkg::stat_t stat;

  mbid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .busy       (busy),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  mbid_dp #(
    .SLOT_BITS   (SLOT_BITS),
    .FANOUT_BITS (FANOUT_BITS),
    .DEPTH_BITS  (DEPTH_BITS),
    .LEVEL_SHIFT (LEVEL_SHIFT),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .slot_pointer_i      (slot_pointer_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .allocated_pointer_o (allocated_pointer_o)
  );

endmodule
